// ===== rtl/ezyx_pkg.sv =====
// Shared types, widths and constants for the ZYX Euler angle unit.
package ezyx_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;

  // Squared magnitude scaled by 2^28, and its square root.
  localparam int SQ_W   = 60;
  localparam int ROOT_W = 30;
  localparam int REM_W  = 34;

  // CORDIC vector and angle accumulator widths (angle in 2^-24 rad).
  localparam int CW = 34;
  localparam int ZW = 29;

  localparam logic signed [ZW-1:0] ANG_PI = ZW'(52707179);
  localparam logic [16:0] OUT_PI      = 17'd25736;
  localparam logic [16:0] OUT_HALF_PI = 17'd12868;
  localparam logic [13:0] TOL_RESET   = 14'd8;

  localparam logic [23:0] ATAN_TAB [ATAN_LEN] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } pose_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   n;
    pose_t             pose;
  } sqrt_t;

  typedef struct packed {
    logic                 byp;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

endpackage

// ===== rtl/rotation_to_zyx_euler_unit.sv =====
// Top level of the rotation matrix to ZYX Euler angle unit.
//
// Usage: drive the five matrix entries (Q2.14) on in_m00..in_m22 and pulse
// start. busy is always low, so a new matrix may be started in every cycle.
// Each matrix gives one result word: out_yaw_angle and out_roll_angle in
// Q3.13 radians, out_pitch_angle in Q2.13, plus out_singular, shown for one cycle
// while out_valid is high. The receiver cannot stall the unit and must take
// every result word in the cycle it appears.
// Each matrix passes input capture, the registered squares, the squared magnitude,
// thirty cells of the square root chain, the setup register, NS CORDIC cells (NS is
// CORDIC_STAGES capped at 24), then the rounding and the output registers.
// Throughput: one matrix per cycle; every stage is its own register.
// The singular tolerance is written over the cfg_ channel, which is always
// ready; write it only while no matrix is in flight.
// Reset clears the valid line and sets the tolerance to 8.
module rotation_to_zyx_euler_unit
  import ezyx_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_m00,
  input  logic signed [15:0] in_m10,
  input  logic signed [15:0] in_m20,
  input  logic signed [15:0] in_m21,
  input  logic signed [15:0] in_m22,
  output logic               out_valid,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle,
  output logic               out_singular,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [13:0]        cfg_singular_tolerance
);

  localparam int NS    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int NSQ   = ROOT_W;
  localparam int LAT   = NS + NSQ + 6;

  function automatic lane_t cordic_init(input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] x);
    lane_t l;
    l.byp = 1'b0;
    l.x   = x;
    l.y   = y;
    l.z   = '0;
    if (y == '0) begin
      l.byp = 1'b1;
      l.z   = x[CW-1] ? ANG_PI : '0;
    end else if (x[CW-1]) begin
      l.z = y[CW-1] ? -ANG_PI : ANG_PI;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  function automatic logic signed [16:0] round_sat(input logic signed [ZW-1:0] z,
                                                   input logic [16:0] lim);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] q;
    logic [16:0]   qs;
    mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    q   = (mag + ZW'(1024)) >> 11;
    qs  = (q > ZW'(lim)) ? lim : q[16:0];
    return z[ZW-1] ? -$signed(qs) : $signed(qs);
  endfunction

  logic [LAT-1:0] vld_r, vld_nxt;
  logic [13:0]    tol_r, tol_nxt;

  pose_t        pose0_r, pose1_r, pose2_r;
  logic [31:0]  p00_r, p10_r;
  logic [31:0]  p00_full, p10_full;
  logic [SQ_W-1:0] n2_r;

  sqrt_t sq [NSQ+1];
  lane_t yl [NS+1];
  lane_t pl [NS+1];
  lane_t rl [NS+1];

  lane_t yl0_nxt, pl0_nxt, rl0_nxt;

  logic signed [16:0] yaw_r, pitch_r, roll_r;
  logic signed [16:0] yaw_nxt, pitch_nxt, roll_nxt;
  logic [16:0]        pmag;
  logic               sing_nxt;

  logic signed [15:0] yaw_o_r, roll_o_r;
  logic signed [14:0] pitch_o_r;
  logic               sing_o_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], start & ~busy};
    tol_nxt = (cfg_valid && cfg_ready) ? cfg_singular_tolerance : tol_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tol_r <= TOL_RESET;
    end else begin
      vld_r <= vld_nxt;
      tol_r <= tol_nxt;
    end
  end

  // Input capture, squares, then the scaled squared magnitude.
  assign p00_full = 32'(pose0_r.m00 * pose0_r.m00);
  assign p10_full = 32'(pose0_r.m10 * pose0_r.m10);

  always_ff @(posedge clk) begin
    pose0_r <= '{in_m00, in_m10, in_m20, in_m21, in_m22};
    p00_r   <= p00_full;
    p10_r   <= p10_full;
    pose1_r <= pose0_r;
    n2_r    <= {32'(p00_r + p10_r), 28'd0};
    pose2_r <= pose1_r;
  end

  assign sq[0] = '{rem: '0, root: '0, n: n2_r, pose: pose2_r};

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    ezyx_sqrt_cell u_cell (
      .clk   (clk),
      .d_in  (sq[i]),
      .d_out (sq[i+1])
    );
  end

  // Setup of the three CORDIC lanes from the root and the carried pose.
  always_comb begin
    yl0_nxt = cordic_init({{4{sq[NSQ].pose.m10[15]}}, sq[NSQ].pose.m10, 14'd0},
                          {{4{sq[NSQ].pose.m00[15]}}, sq[NSQ].pose.m00, 14'd0});
    pl0_nxt = cordic_init(-{{4{sq[NSQ].pose.m20[15]}}, sq[NSQ].pose.m20, 14'd0},
                          {{(CW-ROOT_W){1'b0}}, sq[NSQ].root});
    rl0_nxt = cordic_init({{4{sq[NSQ].pose.m21[15]}}, sq[NSQ].pose.m21, 14'd0},
                          {{4{sq[NSQ].pose.m22[15]}}, sq[NSQ].pose.m22, 14'd0});
  end

  always_ff @(posedge clk) begin
    yl[0] <= yl0_nxt;
    pl[0] <= pl0_nxt;
    rl[0] <= rl0_nxt;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    ezyx_cordic_cell #(.SHIFT(i)) u_yaw   (.clk(clk), .d_in(yl[i]), .d_out(yl[i+1]));
    ezyx_cordic_cell #(.SHIFT(i)) u_pitch (.clk(clk), .d_in(pl[i]), .d_out(pl[i+1]));
    ezyx_cordic_cell #(.SHIFT(i)) u_roll  (.clk(clk), .d_in(rl[i]), .d_out(rl[i+1]));
  end

  // Rounding to Q3.13 with saturation, then the gimbal lock flag.
  always_comb begin
    yaw_nxt   = round_sat(yl[NS].z, OUT_PI);
    pitch_nxt = round_sat(pl[NS].z, OUT_HALF_PI);
    roll_nxt  = round_sat(rl[NS].z, OUT_PI);
    pmag      = pitch_r[16] ? 17'(-pitch_r) : 17'(pitch_r);
    sing_nxt  = (OUT_HALF_PI - pmag) < {3'd0, tol_r};
  end

  always_ff @(posedge clk) begin
    yaw_r     <= yaw_nxt;
    pitch_r   <= pitch_nxt;
    roll_r    <= roll_nxt;
    yaw_o_r   <= yaw_r[15:0];
    pitch_o_r <= pitch_r[14:0];
    roll_o_r  <= roll_r[15:0];
    sing_o_r  <= sing_nxt;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_yaw_angle   = yaw_o_r;
  assign out_pitch_angle = pitch_o_r;
  assign out_roll_angle  = roll_o_r;
  assign out_singular    = sing_o_r;

endmodule

// ===== rtl/ezyx_sqrt_cell.sv =====
// One result bit of the pipelined integer square root, with the pose carried along.
module ezyx_sqrt_cell
  import ezyx_pkg::*;
(
  input  logic  clk,
  input  sqrt_t d_in,
  output sqrt_t d_out
);

  sqrt_t            q_r, q_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    rem_sh = {d_in.rem[REM_W-3:0], d_in.n[SQ_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, d_in.root, 2'b01};
    q_nxt      = d_in;
    q_nxt.n    = {d_in.n[SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = rem_sh - trial;
      q_nxt.root = {d_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh;
      q_nxt.root = {d_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign d_out = q_r;

endmodule

// ===== rtl/ezyx_cordic_cell.sv =====
// One vectoring iteration of a CORDIC lane.
module ezyx_cordic_cell
  import ezyx_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic  clk,
  input  lane_t d_in,
  output lane_t d_out
);

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[SHIFT]);

  lane_t                q_r, q_nxt;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs    = d_in.x >>> SHIFT;
    ys    = d_in.y >>> SHIFT;
    q_nxt = d_in;
    if (!d_in.byp) begin
      if (!d_in.y[CW-1]) begin
        q_nxt.x = d_in.x + ys;
        q_nxt.y = d_in.y - xs;
        q_nxt.z = d_in.z + ANG;
      end else begin
        q_nxt.x = d_in.x - ys;
        q_nxt.y = d_in.y + xs;
        q_nxt.z = d_in.z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign d_out = q_r;

endmodule
